[rtl/gcm_ghash_tag_engine_macros.svh]
// Assertion macros shared by the checker of the GHASH tag engine.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef GCM_GHASH_TAG_ENGINE_MACROS_SVH
`define GCM_GHASH_TAG_ENGINE_MACROS_SVH

// Condition in this cycle implies the consequence in the same cycle.
`define GGT_ASSERT_NOW(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error("ggt assertion failed (same cycle)");

// Condition in this cycle implies the consequence in the next cycle.
`define GGT_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error("ggt assertion failed (next cycle)");

`endif

[rtl/ggt_pkg.sv]
// Package for the GHASH tag engine: request codes, register indexes, widths and types.
// Depends on nothing; used by every module of the engine.
package ggt_pkg;

    localparam int COUNT_BITS_DEF = 32;

    localparam int BLOCK_BITS  = 128;
    localparam int HALF_BITS   = 64;
    localparam int BLOCK_BYTES = 16;
    localparam int VB_BITS     = 5;

    // GF(2^128) multiplier: one 8-bit digit of H per cycle.
    localparam int MUL_DIGIT = 8;
    localparam int MUL_STEPS = BLOCK_BITS / MUL_DIGIT;
    localparam int MUL_CNT_BITS = $clog2(MUL_STEPS);
    localparam logic [7:0] GF_POLY_BYTE = 8'hE1;

    // Stream widths.
    localparam int S_TDATA_BITS = 136;
    localparam int S_TUSER_BITS = 2;
    localparam int M_TDATA_BITS = 136;
    localparam int VB_LSB       = 2 * HALF_BITS;
    localparam int MATCH_BIT    = 2 * HALF_BITS;

    // Request codes carried in s_tuser.
    localparam logic [1:0] REQ_AAD    = 2'd0;
    localparam logic [1:0] REQ_TEXT   = 2'd1;
    localparam logic [1:0] REQ_FINISH = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [1:0] CFG_HASH_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_HASH_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_TAG_MASK_HIGH = 2'd2;
    localparam logic [1:0] CFG_TAG_MASK_LOW  = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MUL  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_sts_t;

endpackage

[rtl/ggt_gf_mul.sv]
// Digit-serial GF(2^128) multiplier (GCM bit order), 8 bits of H per cycle.
// Depends on ggt_pkg.
module ggt_gf_mul
    import ggt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mul_ctl_t              ctl,
    input  logic [BLOCK_BITS-1:0] a,
    input  logic [BLOCK_BITS-1:0] h,
    output mul_sts_t              sts,
    output logic [BLOCK_BITS-1:0] product
);

    logic [BLOCK_BITS-1:0]   v_reg, v_next;
    logic [BLOCK_BITS-1:0]   z_reg, z_next;
    logic [BLOCK_BITS-1:0]   h_reg, h_next;
    logic [MUL_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;

    // One digit: eight shift-and-reduce steps, H bits taken from the top.
    always_comb
    begin
        logic [BLOCK_BITS-1:0] v;
        logic [BLOCK_BITS-1:0] z;
        v = v_reg;
        z = z_reg;
        for (int k = 0; k < MUL_DIGIT; k++)
        begin
            if (h_reg[BLOCK_BITS-1-k])
            begin
                z = z ^ v;
            end
            v = {1'b0, v[BLOCK_BITS-1:1]}
                ^ ({GF_POLY_BYTE, {(BLOCK_BITS-8){1'b0}}} & {BLOCK_BITS{v[0]}});
        end

        v_next    = v_reg;
        z_next    = z_reg;
        h_next    = h_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctl.start)
        begin
            v_next    = a;
            z_next    = '0;
            h_next    = h;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            v_next   = v;
            z_next   = z;
            h_next   = {h_reg[BLOCK_BITS-MUL_DIGIT-1:0], {MUL_DIGIT{1'b0}}};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_BITS'(MUL_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        z_reg <= z_next;
        h_reg <= h_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign product  = z_reg;

endmodule

[rtl/gcm_ghash_tag_engine.sv]
// Top level of the GCM GHASH tag engine: request handling, counters, tag output.
// Depends on ggt_pkg and ggt_gf_mul.
//
//  Channel  | Signals                          | Carries
//  ---------+----------------------------------+-----------------------------------------
//  s_*      | s_tvalid s_tready s_tdata s_tuser | AAD, text and finish requests
//  m_*      | m_tvalid m_tready m_tdata         | computed tag and match flag (finish only)
//  cfg_*    | cfg_we cfg_index cfg_data         | hash subkey H and tag mask E_K(J0)
//
// A block request with one or more valid bytes holds the engine while the shared
// digit-serial multiplier works (one 8-bit digit of H per cycle) and while the
// product is written back. A finish request runs the same multiply, then presents
// its result as soon as the output register is free. Requests of unused type or
// with zero valid bytes are taken and change nothing.
// Reset clears the accumulator, the byte counters and the configuration registers.
// A stalled result stays in the output register; the engine goes on taking blocks.
module gcm_ghash_tag_engine
    import ggt_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    // Requests.
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // s_tdata, lowest bit first: block_high[63:0], block_low[63:0], valid_bytes[4:0], pad
    input  logic [S_TDATA_BITS-1:0]   s_tdata,
    // s_tuser: req_type[1:0]
    input  logic [S_TUSER_BITS-1:0]   s_tuser,
    // Results.
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // m_tdata, lowest bit first: tag_high[63:0], tag_low[63:0], tag_match, pad
    output logic [M_TDATA_BITS-1:0]   m_tdata,
    // Configuration writes.
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [HALF_BITS-1:0]      cfg_data
);

    state_t                state_reg, state_next;
    logic [BLOCK_BITS-1:0] accum_reg, accum_next;
    logic [COUNT_BITS-1:0] aad_reg, aad_next;
    logic [COUNT_BITS-1:0] text_reg, text_next;
    logic [BLOCK_BITS-1:0] rx_tag_reg, rx_tag_next;
    logic                  finish_reg, finish_next;
    logic [BLOCK_BITS-1:0] hkey_reg;
    logic [BLOCK_BITS-1:0] tmask_reg;
    logic                  m_valid_reg, m_valid_next;
    logic [BLOCK_BITS-1:0] out_tag_reg, out_tag_next;
    logic                  out_match_reg, out_match_next;

    logic [HALF_BITS-1:0]  blk_high;
    logic [HALF_BITS-1:0]  blk_low;
    logic [VB_BITS-1:0]    vb_raw;
    logic [VB_BITS-1:0]    vb;
    logic [BLOCK_BITS-1:0] blk;
    logic [BLOCK_BITS-1:0] blk_mask;
    logic [BLOCK_BITS-1:0] len_block;
    logic [COUNT_BITS:0]   count_sum;
    logic [COUNT_BITS-1:0] count_sat;
    logic [BLOCK_BITS-1:0] tag_value;
    logic                  accept;
    logic                  is_block;
    logic                  out_free;

    mul_ctl_t              mul_ctl;
    mul_sts_t              mul_sts;
    logic [BLOCK_BITS-1:0] mul_a;
    logic [BLOCK_BITS-1:0] mul_product;

    assign blk_high = s_tdata[HALF_BITS-1:0];
    assign blk_low  = s_tdata[2*HALF_BITS-1:HALF_BITS];
    assign vb_raw   = s_tdata[VB_LSB+VB_BITS-1:VB_LSB];
    assign blk      = {blk_high, blk_low};

    // Valid-byte counts above a full block count as a full block.
    assign vb = (vb_raw > VB_BITS'(BLOCK_BYTES)) ? VB_BITS'(BLOCK_BYTES) : vb_raw;

    // Byte 0 sits in the top eight bits of the block; trailing bytes are zeroed.
    always_comb
    begin
        for (int j = 0; j < BLOCK_BYTES; j++)
        begin
            blk_mask[BLOCK_BITS-1-8*j -: 8] = (VB_BITS'(j) < vb) ? 8'hFF : 8'h00;
        end
    end

    // The length block holds both counts in bits, AAD in the upper half.
    assign len_block = {HALF_BITS'({aad_reg, 3'b000}), HALF_BITS'({text_reg, 3'b000})};

    // Saturating byte count for whichever counter the request feeds.
    assign count_sum = (s_tuser == REQ_AAD) ? ({1'b0, aad_reg} + (COUNT_BITS+1)'(vb))
                                            : ({1'b0, text_reg} + (COUNT_BITS+1)'(vb));
    assign count_sat = count_sum[COUNT_BITS] ? {COUNT_BITS{1'b1}}
                                             : count_sum[COUNT_BITS-1:0];

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign is_block = ((s_tuser == REQ_AAD) || (s_tuser == REQ_TEXT)) && (vb_raw != '0);
    assign out_free = !m_valid_reg || m_tready;

    assign tag_value = accum_reg ^ tmask_reg;

    always_comb
    begin
        state_next     = state_reg;
        accum_next     = accum_reg;
        aad_next       = aad_reg;
        text_next      = text_reg;
        rx_tag_next    = rx_tag_reg;
        finish_next    = finish_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        out_tag_next   = out_tag_reg;
        out_match_next = out_match_reg;
        mul_ctl.start  = 1'b0;
        mul_a          = accum_reg ^ (blk & blk_mask);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_block)
                begin
                    mul_ctl.start = 1'b1;
                    finish_next   = 1'b0;
                    state_next    = ST_MUL;
                    if (s_tuser == REQ_AAD)
                    begin
                        aad_next = count_sat;
                    end
                    else
                    begin
                        text_next = count_sat;
                    end
                end
                else if (accept && (s_tuser == REQ_FINISH))
                begin
                    mul_a         = accum_reg ^ len_block;
                    mul_ctl.start = 1'b1;
                    finish_next   = 1'b1;
                    rx_tag_next   = blk;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_sts.done)
                begin
                    accum_next = mul_product;
                    state_next = finish_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                // Wait for the output register, then hand out the tag and start over.
                if (out_free)
                begin
                    m_valid_next   = 1'b1;
                    out_tag_next   = tag_value;
                    out_match_next = (tag_value == rx_tag_reg);
                    accum_next     = '0;
                    aad_next       = '0;
                    text_next      = '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            accum_reg   <= '0;
            aad_reg     <= '0;
            text_reg    <= '0;
            finish_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            hkey_reg    <= '0;
            tmask_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            accum_reg   <= accum_next;
            aad_reg     <= aad_next;
            text_reg    <= text_next;
            finish_reg  <= finish_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_HASH_KEY_HIGH: hkey_reg[BLOCK_BITS-1:HALF_BITS]  <= cfg_data;
                    CFG_HASH_KEY_LOW:  hkey_reg[HALF_BITS-1:0]           <= cfg_data;
                    CFG_TAG_MASK_HIGH: tmask_reg[BLOCK_BITS-1:HALF_BITS] <= cfg_data;
                    CFG_TAG_MASK_LOW:  tmask_reg[HALF_BITS-1:0]          <= cfg_data;
                    default:           hkey_reg                          <= hkey_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rx_tag_reg    <= rx_tag_next;
        out_tag_reg   <= out_tag_next;
        out_match_reg <= out_match_next;
    end

    ggt_gf_mul u_gf_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mul_ctl),
        .a       (mul_a),
        .h       (hkey_reg),
        .sts     (mul_sts),
        .product (mul_product)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_BITS-MATCH_BIT-1){1'b0}}, out_match_reg,
                       out_tag_reg[HALF_BITS-1:0], out_tag_reg[BLOCK_BITS-1:HALF_BITS]};

endmodule

[rtl/ggt_checker.sv]
// Port-level checker for the GHASH tag engine, bound to the top level.
// Depends on ggt_pkg and gcm_ghash_tag_engine_macros.svh.
`include "gcm_ghash_tag_engine_macros.svh"

module ggt_checker
    import ggt_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    s_tvalid,
    input logic                    s_tready,
    input logic [S_TDATA_BITS-1:0] s_tdata,
    input logic [S_TUSER_BITS-1:0] s_tuser,
    input logic                    m_tvalid,
    input logic                    m_tready,
    input logic [M_TDATA_BITS-1:0] m_tdata
);

    logic req_take;
    logic req_works;

    assign req_take  = s_tvalid && s_tready;
    assign req_works = (s_tuser == REQ_FINISH)
                       || (((s_tuser == REQ_AAD) || (s_tuser == REQ_TEXT))
                           && (s_tdata[VB_LSB+VB_BITS-1:VB_LSB] != '0));

    // A request that needs the multiplier holds the engine off the next cycle.
    `GGT_ASSERT_NEXT(a_busy_after_work, clk, rst_n, req_take && req_works, !s_tready)

    // A request that does nothing leaves the engine ready.
    `GGT_ASSERT_NEXT(a_ready_after_noop, clk, rst_n, req_take && !req_works, s_tready)

    // A new result only follows a cycle in which the engine was busy.
    `GGT_ASSERT_NOW(a_result_after_busy, clk, rst_n, $rose(m_tvalid), $past(!s_tready))

    // A stalled result keeps its value.
    `GGT_ASSERT_NEXT(a_result_holds, clk, rst_n, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata))

endmodule

bind gcm_ghash_tag_engine ggt_checker u_ggt_checker (.*);
